// ----- sv/fcsl_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsl_pkg
// Shared types and constants for the frame check sequence loss counter.
// ----------------------------------------------------------------------------
package fcsl_pkg;

    // Input item kinds (carried on tuser)
    localparam logic OP_DATA      = 1'b0;
    localparam logic OP_LINK_LOST = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  CFG_HEADER_WORD = 1'b0;
    localparam logic [0:0]  CFG_TAIL_WORD   = 1'b1;

    // Configuration reset values
    localparam logic [15:0] HEADER_WORD_RST = 16'h55AA;
    localparam logic [15:0] TAIL_WORD_RST   = 16'hAA55;

    // Tail offset base: header, sequence and length words precede the payload
    localparam logic [15:0] TAIL_BASE = 16'd6;

    // Number of head bytes kept per packet
    localparam int HEAD_BYTES = 8;

    // Per-transfer control handed from the input stage to the datapath
    typedef struct packed {
        logic fire;       // input register hands its item on this cycle
        logic link_lost;  // item is a link-lost event
        logic last;       // item is the last byte of a packet
    } t_step;

    // One result item
    typedef struct packed {
        logic        frame_ok;
        logic [15:0] seq_number;
        logic [15:0] gap;
        logic [31:0] total_frames;
        logic [31:0] total_lost;
    } t_result;

endpackage

// ----- sv/fcsl_frame_eval.sv -----
// ----------------------------------------------------------------------------
// fcsl_frame_eval
// Tracks one packet: byte count, head bytes and tail capture, and checks
// header and tail on the last byte.
// ----------------------------------------------------------------------------
module fcsl_frame_eval #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int CW               = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcsl_pkg::t_step      i_step,
    input  logic [7:0]           i_byte_value,
    input  logic [15:0]          i_header_word,
    input  logic [15:0]          i_tail_word,
    output logic                 o_frame_ok,
    output logic [15:0]          o_seq_number
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_head [fcsl_pkg::HEAD_BYTES];
    logic [7:0]    n_head [fcsl_pkg::HEAD_BYTES];
    logic [7:0]    r_tail_lo;
    logic [7:0]    n_tail_lo;
    logic [7:0]    r_tail_hi;
    logic [7:0]    n_tail_hi;

    logic          in_range;
    logic          past_len;
    logic [15:0]   tail_pos;
    logic [16:0]   tail_pos1;
    logic [16:0]   tail_end;
    logic [16:0]   pos_ext;
    logic [16:0]   len_ext;
    logic [7:0]    tail_lo_sel;
    logic [7:0]    tail_hi_sel;
    logic [15:0]   tail_rx_word;
    logic [15:0]   hdr_val;

    // Tail position from the stored length field
    assign tail_pos  = fcsl_pkg::TAIL_BASE + {r_head[5], r_head[4]};
    assign tail_pos1 = {1'b0, tail_pos} + 17'd1;
    assign tail_end  = {1'b0, tail_pos} + 17'd2;
    assign pos_ext   = 17'(r_count);
    assign in_range  = r_count < CW'(MAX_PACKET_BYTES);
    assign past_len  = r_count >= CW'(6);

    // Store the incoming byte
    always_comb begin
        for (int k = 0; k < fcsl_pkg::HEAD_BYTES; k++) begin
            n_head[k] = (in_range && r_count == CW'(k)) ? i_byte_value : r_head[k];
        end
        n_tail_lo = (in_range && past_len && pos_ext == {1'b0, tail_pos})
                    ? i_byte_value : r_tail_lo;
        n_tail_hi = (in_range && past_len && pos_ext == tail_pos1)
                    ? i_byte_value : r_tail_hi;
        n_count   = in_range ? r_count + CW'(1) : r_count;
    end

    // Check header and tail against the packet including this byte
    assign len_ext      = 17'(n_count);
    assign tail_lo_sel  = (tail_pos < 16'd8) ? n_head[tail_pos[2:0]] : n_tail_lo;
    assign tail_hi_sel  = (tail_pos1 < 17'd8) ? n_head[tail_pos1[2:0]] : n_tail_hi;
    assign tail_rx_word = (tail_end <= len_ext) ? {tail_hi_sel, tail_lo_sel} : 16'd0;
    assign hdr_val      = {n_head[1], n_head[0]};

    assign o_frame_ok   = (n_count >= CW'(8)) && (hdr_val == i_header_word)
                          && (tail_rx_word == i_tail_word);
    assign o_seq_number = {n_head[3], n_head[2]};

    // Advance packet state; clear at packet end or link loss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_tail_lo <= '0;
            r_tail_hi <= '0;
            for (int k = 0; k < fcsl_pkg::HEAD_BYTES; k++) begin
                r_head[k] <= '0;
            end
        end else if (i_step.fire) begin
            if (i_step.link_lost || i_step.last) begin
                r_count   <= '0;
                r_tail_lo <= '0;
                r_tail_hi <= '0;
                for (int k = 0; k < fcsl_pkg::HEAD_BYTES; k++) begin
                    r_head[k] <= '0;
                end
            end else begin
                r_count   <= n_count;
                r_tail_lo <= n_tail_lo;
                r_tail_hi <= n_tail_hi;
                for (int k = 0; k < fcsl_pkg::HEAD_BYTES; k++) begin
                    r_head[k] <= n_head[k];
                end
            end
        end
    end

endmodule

// ----- sv/fcsl_loss_acc.sv -----
// ----------------------------------------------------------------------------
// fcsl_loss_acc
// Holds the expected sequence number and the frame and loss totals.
// ----------------------------------------------------------------------------
module fcsl_loss_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcsl_pkg::t_step      i_step,
    input  logic                 i_frame_ok,
    input  logic [15:0]          i_seq_number,
    output logic [15:0]          o_gap,
    output logic [31:0]          o_total_frames,
    output logic [31:0]          o_total_lost
);

    logic        r_armed;
    logic [15:0] r_expected;
    logic [31:0] r_frames;
    logic [31:0] r_lost;
    logic        frame_hit;

    assign frame_hit = i_step.fire && !i_step.link_lost && i_step.last && i_frame_ok;

    // Gap counts only once the expectation is armed
    assign o_gap          = (i_frame_ok && r_armed) ? i_seq_number - r_expected : 16'd0;
    assign o_total_frames = i_frame_ok ? r_frames + 32'd1 : r_frames;
    assign o_total_lost   = r_lost + 32'(o_gap);

    // Update expectation and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_expected <= '0;
            r_frames   <= '0;
            r_lost     <= '0;
        end else if (i_step.fire && i_step.link_lost) begin
            r_armed <= 1'b0;
        end else if (frame_hit) begin
            r_armed    <= 1'b1;
            r_expected <= i_seq_number + 16'd1;
            r_frames   <= o_total_frames;
            r_lost     <= o_total_lost;
        end
    end

endmodule

// ----- sv/frame_check_sequence_loss_counter.sv -----
// ----------------------------------------------------------------------------
// frame_check_sequence_loss_counter
// Byte-serial packet checker that counts frames and sequence-number gaps.
// ----------------------------------------------------------------------------
// Throughput: one byte transfer per cycle while the result stream keeps up;
// a last byte waits in the input register while the result register is full.
// A last byte passes the input register, then its result the result register.
// Rate is set by the single pass from the input register to the result register.
// Reset (i_rst_n low, synchronous) clears packet state, totals, expectation
// and restores header_word and tail_word to their defaults.
module frame_check_sequence_loss_counter #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] byte_value
    input  logic                           i_s_axis_tuser,  // [0] opcode
    input  logic                           i_s_axis_tlast,  // last_byte
    // Result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] seq_number, [31:16] gap, [63:32] total_frames, [95:64] total_lost
    output logic [95:0]                    o_m_axis_tdata,
    output logic                           o_m_axis_tuser,  // [0] frame_ok
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcsl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    logic [15:0]       r_header_word;
    logic [15:0]       r_tail_word;

    logic              r_a_valid;
    logic              r_a_opcode;
    logic [7:0]        r_a_byte;
    logic              r_a_last;

    logic              r_out_valid;
    fcsl_pkg::t_result r_out;
    fcsl_pkg::t_result n_out;

    logic              ev_frame_ok;
    logic [15:0]       ev_seq_number;
    logic [15:0]       acc_gap;
    logic [31:0]       acc_total_frames;
    logic [31:0]       acc_total_lost;

    logic              a_has_res;
    logic              out_free;
    logic              a_fire;
    logic              s_accept;
    fcsl_pkg::t_step   step;

    // Configuration registers; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word <= fcsl_pkg::HEADER_WORD_RST;
            r_tail_word   <= fcsl_pkg::TAIL_WORD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fcsl_pkg::CFG_HEADER_WORD: r_header_word <= i_cfg_data;
                fcsl_pkg::CFG_TAIL_WORD:   r_tail_word   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the input item moves on unless its result finds the output full
    assign a_has_res       = (r_a_opcode == fcsl_pkg::OP_DATA) && r_a_last;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign a_fire          = r_a_valid && (!a_has_res || out_free);
    assign o_s_axis_tready = !r_a_valid || a_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign step.fire      = a_fire;
    assign step.link_lost = (r_a_opcode == fcsl_pkg::OP_LINK_LOST);
    assign step.last      = r_a_last;

    // Input register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_opcode <= i_s_axis_tuser;
            r_a_byte   <= i_s_axis_tdata;
            r_a_last   <= i_s_axis_tlast;
        end
    end

    fcsl_frame_eval #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_frame_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte_value  (r_a_byte),
        .i_header_word (r_header_word),
        .i_tail_word   (r_tail_word),
        .o_frame_ok    (ev_frame_ok),
        .o_seq_number  (ev_seq_number)
    );

    fcsl_loss_acc u_loss_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_frame_ok     (ev_frame_ok),
        .i_seq_number   (ev_seq_number),
        .o_gap          (acc_gap),
        .o_total_frames (acc_total_frames),
        .o_total_lost   (acc_total_lost)
    );

    // Gather the result fields
    assign n_out = {ev_frame_ok, ev_seq_number, acc_gap, acc_total_frames, acc_total_lost};

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_fire && a_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (a_fire && a_has_res) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.frame_ok;
    assign o_m_axis_tdata  = {r_out.total_lost, r_out.total_frames,
                              r_out.gap, r_out.seq_number};

endmodule
